FILE: src/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg
// shared types, widths and codes of the bounded position deque
// ----------------------------------------------------------------------------
`default_nettype none

package bpd_pkg;

  localparam int CAPACITY = 256;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = 8;
  localparam int COORD_W  = 8;
  localparam int SIZE_W   = 9;
  localparam int STAT_W   = 2;
  localparam int OP_W     = 3;
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int ENTRY_W  = 3 * COORD_W;
  localparam int GRP_SIZE = 16;
  localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  localparam int IN_TDATA_W  = 4 * COORD_W;
  localparam int OUT_DATA_W  = ENTRY_W + SIZE_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_RM_HEAD  = 3'd2,
    OP_RM_TAIL  = 3'd3,
    OP_RD_IDX   = 3'd4,
    OP_RD_TAIL  = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] symbol;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic             ins_head;
    logic             ins_tail;
    logic             rm_head;
    logic             rm_tail;
    logic             rd_en;
    entry_t           item;
    logic [CMP_W-1:0] tail_pos;
    logic [CMP_W-1:0] rd_pos;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/bpd_cell.sv
// ----------------------------------------------------------------------------
// bpd_cell
// one slot of the deque: shifts with its neighbors, writes or clears at the
// tail, and presents its entry on the read tap when addressed
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bpd_pkg::cell_ctrl_t       ctrl,
  input  wire logic [bpd_pkg::CMP_W-1:0] cell_pos,
  input  wire bpd_pkg::entry_t           left_in,
  input  wire bpd_pkg::entry_t           right_in,
  output bpd_pkg::entry_t                data_out,
  output logic [bpd_pkg::ENTRY_W-1:0]    tap_out
);
  import bpd_pkg::*;

  entry_t             data_r, data_nxt;
  logic [ENTRY_W-1:0] tap_r, tap_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins_head) begin
      data_nxt = left_in;
    end else if (ctrl.rm_head) begin
      data_nxt = right_in;
    end else if (ctrl.ins_tail && (cell_pos == ctrl.tail_pos)) begin
      data_nxt = ctrl.item;
    end else if (ctrl.rm_tail && (cell_pos == ctrl.tail_pos)) begin
      data_nxt = '0;
    end
  end

  always_comb begin
    tap_nxt = tap_r;
    if (ctrl.load) begin
      tap_nxt = (ctrl.rd_en && (cell_pos == ctrl.rd_pos)) ? data_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
      tap_r  <= '0;
    end else begin
      data_r <= data_nxt;
      tap_r  <= tap_nxt;
    end
  end

  assign data_out = data_r;
  assign tap_out  = tap_r;

endmodule

`default_nettype wire

FILE: src/bpd_tap_tree.sv
// ----------------------------------------------------------------------------
// bpd_tap_tree
// registered or-tree that collects the single addressed cell tap
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_tap_tree (
  input  wire logic                      clk,
  input  wire logic                      grp_en,
  input  wire logic [bpd_pkg::ENTRY_W-1:0] taps [bpd_pkg::CAPACITY],
  output logic [bpd_pkg::ENTRY_W-1:0]    rd_data
);
  import bpd_pkg::*;

  logic [ENTRY_W-1:0] grp_r   [NGRP];
  logic [ENTRY_W-1:0] grp_nxt [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | taps[g * GRP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_en) begin
      grp_r <= grp_nxt;
    end
  end

  always_comb begin
    rd_data = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_data = rd_data | grp_r[g];
    end
  end

endmodule

`default_nettype wire

FILE: src/bounded_position_deque.sv
// ----------------------------------------------------------------------------
// bounded_position_deque
// bounded ordered list of (x, y, symbol) entries held in a row of shifting
// cells; insert or remove at either end, read at an index or at the tail
// ----------------------------------------------------------------------------
//  channel  | ports             | content
//  input    | in_t*             | tuser: op; tdata: x, y, symbol, read_index
//  result   | out_t*            | tuser: status; tdata: x, y, symbol, size
//
//  after accept the cells update and latch their read taps, then the group
//  level of the tap or-tree registers, and its final level loads the result
//  register once that register is empty or its result is being taken
//  a new item is accepted once the previous result is in the result register
//  reset clears every cell and the count
//  a stalled result holds in the result register while the next item runs
`default_nettype none

module bounded_position_deque (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [bpd_pkg::IN_TDATA_W-1:0] in_tdata,  // pos_x, pos_y, pos_symbol, read_index
  input  wire logic [bpd_pkg::OP_W-1:0]      in_tuser,  // op
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [bpd_pkg::OUT_TDATA_W-1:0]    out_tdata, // out_x, out_y, out_symbol, list_size
  output logic [bpd_pkg::STAT_W-1:0]         out_tuser  // status
);
  import bpd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_GRP  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  status_t            status_r, status_nxt;
  logic               out_tvalid_r;
  entry_t             out_entry_r;
  logic [SIZE_W-1:0]  out_size_r;
  status_t            out_status_r;

  op_t                in_op;
  entry_t             in_entry;
  logic [IDX_W-1:0]   read_index;
  logic               accept;
  logic               full;
  logic               empty;
  logic [CMP_W-1:0]   count_ext;
  logic [CMP_W-1:0]   idx_ext;
  cell_ctrl_t         ctrl;
  logic               out_load;

  entry_t             cell_data [CAPACITY];
  logic [ENTRY_W-1:0] cell_tap  [CAPACITY];
  logic [ENTRY_W-1:0] rd_data;

  assign in_op      = op_t'(in_tuser);
  assign in_entry   = '{x: in_tdata[COORD_W-1:0],
                        y: in_tdata[2*COORD_W-1:COORD_W],
                        symbol: in_tdata[3*COORD_W-1:2*COORD_W]};
  assign read_index = in_tdata[3*COORD_W+IDX_W-1:3*COORD_W];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign count_ext = CMP_W'(count_r);
  assign idx_ext   = CMP_W'(read_index);

  always_comb begin
    ctrl          = '0;
    ctrl.load     = accept;
    ctrl.item     = in_entry;
    ctrl.tail_pos = (in_op == OP_INS_TAIL) ? count_ext : count_ext - CMP_W'(1);
    ctrl.rd_pos   = (in_op == OP_RD_IDX) ? idx_ext : count_ext - CMP_W'(1);
    status_nxt    = ST_OK;
    count_nxt     = count_r;
    case (in_op)
      OP_INS_HEAD: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.ins_head = accept;
          count_nxt     = count_r + CNT_W'(1);
        end
      end
      OP_INS_TAIL: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.ins_tail = accept;
          count_nxt     = count_r + CNT_W'(1);
        end
      end
      OP_RM_HEAD: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.rm_head = accept;
          count_nxt    = count_r - CNT_W'(1);
        end
      end
      OP_RM_TAIL: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.rm_tail = accept;
          count_nxt    = count_r - CNT_W'(1);
        end
      end
      OP_RD_IDX: begin
        ctrl.rd_en = accept;
        if (idx_ext >= count_ext) begin
          status_nxt = ST_RANGE;
        end
      end
      OP_RD_TAIL: begin
        ctrl.rd_en = accept;
        if (empty) begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_in;
    entry_t right_in;
    if (i == 0) begin : g_first
      assign left_in = in_entry;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    bpd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .cell_pos (CMP_W'(i)),
      .left_in  (left_in),
      .right_in (right_in),
      .data_out (cell_data[i]),
      .tap_out  (cell_tap[i])
    );
  end

  bpd_tap_tree u_tap_tree (
    .clk     (clk),
    .grp_en  (state_r == S_GRP),
    .taps    (cell_tap),
    .rd_data (rd_data)
  );

  assign out_load = (state_r == S_FIN) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_GRP;
        end
      end
      S_GRP: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
    if (out_load) begin
      out_entry_r  <= entry_t'(rd_data);
      out_size_r   <= SIZE_W'(count_r);
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({out_size_r, out_entry_r.symbol, out_entry_r.y,
                                    out_entry_r.x});
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

FILE: src/bpd_checker.sv
// ----------------------------------------------------------------------------
// bpd_checker
// port-level checks of the bounded position deque
// ----------------------------------------------------------------------------
`default_nettype none

module bpd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [bpd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [bpd_pkg::STAT_W-1:0]      out_tuser
);
  import bpd_pkg::*;

  logic [SIZE_W-1:0] out_size;
  assign out_size = out_tdata[ENTRY_W+SIZE_W-1:ENTRY_W];

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_full_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> out_size == SIZE_W'(CAPACITY))
    else $error("full status with list not at capacity");

  a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> out_size == '0)
    else $error("empty status with entries present");

endmodule

bind bounded_position_deque bpd_checker u_bpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: dv/tb_bounded_position_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_position_deque
// drives insert, remove and read operations into the position deque, predicts
// every result with a local model of the list, and checks each result field by
// field under random sender gaps, receiver stalls and one long output stall
// ----------------------------------------------------------------------------

module tb_bounded_position_deque;
  import bpd_pkg::*;

  localparam int          HALF_PERIOD  = 6;
  localparam int          RESET_CYCLES = 7;
  localparam int          RANDOM_ITEMS = 1025;
  localparam int          LONG_HOLD    = 200;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          LIMIT_CYCLES = 200000;
  localparam int          EDGE_HITS    = 6;
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    entry_t            ent;
    logic [SIZE_W-1:0] size;
    status_t           status;
  } deque_result_t;

  typedef enum logic {GROW, SHRINK} trend_t;

  class position_scoreboard;
    entry_t        slots[CAPACITY];
    int unsigned   count;
    deque_result_t pending[$];
    int            n_items;
    int            n_results;
    int            errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      count     = 0;
      n_items   = 0;
      n_results = 0;
      errors    = 0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at result %0d: %s", n_results, what);
      errors++;
    endtask

    function void note_item(logic [OP_W-1:0] op, entry_t item, logic [IDX_W-1:0] idx);
      deque_result_t r;
      int            i;
      r        = '0;
      r.status = ST_OK;
      case (op)
        OP_INS_HEAD: begin
          if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (i = count; i > 0; i--) slots[i] = slots[i-1];
            slots[0] = item;
            count++;
          end
        end
        OP_INS_TAIL: begin
          if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            slots[count] = item;
            count++;
          end
        end
        OP_RM_HEAD: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            for (i = 0; i + 1 < count; i++) slots[i] = slots[i+1];
            slots[count-1] = '0;
            count--;
          end
        end
        OP_RM_TAIL: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            slots[count-1] = '0;
            count--;
          end
        end
        OP_RD_IDX: begin
          if (idx < CAPACITY) r.ent = slots[idx];
          if (idx >= count) r.status = ST_RANGE;
        end
        OP_RD_TAIL: begin
          if (count == 0) r.status = ST_RANGE;
          else r.ent = slots[count-1];
        end
        default: begin
        end
      endcase
      r.size = count[SIZE_W-1:0];
      pending.push_back(r);
      n_items++;
    endfunction

    task check_result(entry_t got_ent, logic [SIZE_W-1:0] got_size,
                      logic [STAT_W-1:0] got_status);
      deque_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        e = pending.pop_front();
        if (got_ent.x != e.ent.x)
          report_mismatch($sformatf("x got %0d exp %0d", got_ent.x, e.ent.x));
        if (got_ent.y != e.ent.y)
          report_mismatch($sformatf("y got %0d exp %0d", got_ent.y, e.ent.y));
        if (got_ent.symbol != e.ent.symbol)
          report_mismatch($sformatf("symbol got %0d exp %0d", got_ent.symbol,
                                    e.ent.symbol));
        if (got_size != e.size)
          report_mismatch($sformatf("size got %0d exp %0d", got_size, e.size));
        if (got_status != e.status)
          report_mismatch($sformatf("status got %0d exp %0d", got_status, e.status));
      end
      n_results++;
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;

  position_scoreboard sb = new();
  int                 burst_left = 0;
  int                 cycles = 0;

  bounded_position_deque DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[ENTRY_W-1:0] == '0 ? '0 :
                      {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16]},
                      out_tdata[ENTRY_W+SIZE_W-1:ENTRY_W], out_tuser);
  end

  // one item, held until accepted, then the sender's burst and gap pacing
  task automatic send_item(logic [OP_W-1:0] op, logic [7:0] x, logic [7:0] y,
                           logic [7:0] sym, logic [7:0] idx);
    entry_t item;
    int     gap;
    item.x      = x;
    item.y      = y;
    item.symbol = sym;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {idx, sym, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, item, idx);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : receiver
    int hold_left;
    int style;
    int style_left;
    bit long_done;
    hold_left  = 0;
    style      = 0;
    style_left = 0;
    long_done  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (style_left == 0) begin
        style      = $urandom_range(0, 2);
        style_left = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!long_done && sb.n_items >= 150) begin
        long_done = 1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else begin
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    trend_t      trend;
    int          edge_hits;
    int          n;
    int          pick;
    logic [2:0]  op;
    logic [7:0]  idx;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corner cases and spare op codes
    send_item(OP_RM_HEAD, 8'h11, 8'h22, 8'h33, 8'h00);
    send_item(OP_RM_TAIL, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(OP_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_RD_IDX,  8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_RD_IDX,  8'h00, 8'h00, 8'h00, 8'hff);
    send_item(OP_SPARE_A, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(OP_SPARE_B, 8'h00, 8'h00, 8'h00, 8'h00);
    // field extremes at both ends, then reads and removals down to empty
    send_item(OP_INS_TAIL, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(OP_INS_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_INS_HEAD, 8'ha5, 8'h5a, 8'h3c, 8'h81);
    send_item(OP_INS_TAIL, 8'h01, 8'h80, 8'h7f, 8'h7e);
    send_item(OP_RD_IDX,   8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_RD_IDX,   8'h00, 8'h00, 8'h00, 8'h01);
    send_item(OP_RD_IDX,   8'h00, 8'h00, 8'h00, 8'h02);
    send_item(OP_RD_IDX,   8'h00, 8'h00, 8'h00, 8'h03);
    send_item(OP_RD_IDX,   8'h00, 8'h00, 8'h00, 8'h04);
    send_item(OP_RD_IDX,   8'h00, 8'h00, 8'h00, 8'hff);
    send_item(OP_RD_TAIL,  8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_SPARE_B,  8'h12, 8'h34, 8'h56, 8'h02);
    send_item(OP_RM_HEAD,  8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_RD_IDX,   8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_RM_TAIL,  8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_RD_TAIL,  8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_RM_HEAD,  8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_RM_TAIL,  8'h00, 8'h00, 8'h00, 8'h00);
    send_item(OP_RM_TAIL,  8'h00, 8'h00, 8'h00, 8'h00);

    // random part swings the list between full and empty
    trend     = GROW;
    edge_hits = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (trend == GROW && sb.count == CAPACITY) begin
        edge_hits++;
        if (edge_hits >= EDGE_HITS) begin
          trend     = SHRINK;
          edge_hits = 0;
        end
      end else if (trend == SHRINK && sb.count == 0) begin
        edge_hits++;
        if (edge_hits >= EDGE_HITS) begin
          trend     = GROW;
          edge_hits = 0;
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
        if (trend == GROW) op = pick[0] ? OP_INS_HEAD : OP_INS_TAIL;
        else op = pick[0] ? OP_RM_HEAD : OP_RM_TAIL;
      end else if (pick < 91) begin
        if (trend == GROW) op = pick[0] ? OP_RM_HEAD : OP_RM_TAIL;
        else op = pick[0] ? OP_INS_HEAD : OP_INS_TAIL;
      end else if (pick < 96) begin
        op = OP_RD_IDX;
      end else if (pick < 98) begin
        op = OP_RD_TAIL;
      end else begin
        op = pick[0] ? OP_SPARE_A : OP_SPARE_B;
      end
      if (sb.count > 0 && $urandom_range(0, 3) != 0)
        idx = 8'($urandom_range(0, sb.count - 1));
      else idx = 8'($urandom);
      send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), idx);
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/bpd_pkg.sv
src/bpd_cell.sv
src/bpd_tap_tree.sv
src/bounded_position_deque.sv
src/bpd_checker.sv
dv/tb_bounded_position_deque.sv
